// ===== design/artdmx_pkg.sv =====
`timescale 1ns / 1ps

package artdmx_pkg;

    localparam int CHANNELS_DEFAULT     = 512;
    localparam int MAX_DATAGRAM_DEFAULT = 530;

    localparam int HEADER_BYTES  = 18;
    localparam int ID_BYTES      = 8;
    localparam int ADDR_W        = 10;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int REG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 16;

    localparam logic [15:0] ARTDMX_OPCODE = 16'h5000;

    // configuration register indexes
    localparam logic [REG_INDEX_W-1:0] REG_RECEIVE_ENABLE  = 2'd0;
    localparam logic [REG_INDEX_W-1:0] REG_WANTED_UNIVERSE = 2'd1;

    // item opcodes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_READ = 1'b1;

    // result kinds
    localparam logic KIND_VERDICT = 1'b0;
    localparam logic KIND_READ    = 1'b1;

    // packet status codes
    localparam logic [2:0] ST_ACCEPTED       = 3'd0;
    localparam logic [2:0] ST_TOO_SHORT      = 3'd1;
    localparam logic [2:0] ST_BAD_ID         = 3'd2;
    localparam logic [2:0] ST_BAD_OPCODE     = 3'd3;
    localparam logic [2:0] ST_OTHER_UNIVERSE = 3'd4;

    typedef struct packed {
        logic       opcode;
        logic [7:0] data_byte;
        logic       last_byte;
        logic [8:0] channel_index;
    } item_t;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] channel_value;
        logic [2:0] packet_status;
    } result_t;

    // one classified operation for the back end
    typedef struct packed {
        logic              do_write;
        logic              do_read;
        logic              emit;
        logic              kind;
        logic [2:0]        status;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } cmd_t;

    function automatic logic [7:0] id_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h41;
            3'd1:    c = 8'h72;
            3'd2:    c = 8'h74;
            3'd3:    c = 8'h2d;
            3'd4:    c = 8'h4e;
            3'd5:    c = 8'h65;
            3'd6:    c = 8'h74;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== design/artdmx_front.sv =====
`timescale 1ns / 1ps

module artdmx_front
    import artdmx_pkg::*;
#(
    parameter int CHANNELS     = CHANNELS_DEFAULT,
    parameter int MAX_DATAGRAM = MAX_DATAGRAM_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [REG_INDEX_W-1:0] wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data,
    input  logic                   take,
    input  item_t                  item,
    output logic                   push,
    output cmd_t                   push_cmd
);

    localparam int POS_W = $clog2(MAX_DATAGRAM + 1);
    localparam int LEN_W = $clog2(CHANNELS + 1);

    logic             enable_reg, enable_next;
    logic [15:0]      wanted_reg, wanted_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             id_ok_reg, id_ok_next;
    logic [15:0]      opc_reg, opc_next;
    logic [15:0]      univ_reg, univ_next;
    logic [7:0]       len_hi_reg, len_hi_next;
    logic [LEN_W-1:0] declared_reg, declared_next;
    logic [LEN_W-1:0] staged_reg, staged_next;
    logic             active_reg, active_next;
    logic [LEN_W-1:0] committed_reg, committed_next;

    logic [POS_W-1:0] d;
    logic [15:0]      len16;
    logic [2:0]       status;
    logic             wrote;
    logic             restart;

    always_comb
    begin
        enable_next    = enable_reg;
        wanted_next    = wanted_reg;
        pos_next       = pos_reg;
        id_ok_next     = id_ok_reg;
        opc_next       = opc_reg;
        univ_next      = univ_reg;
        len_hi_next    = len_hi_reg;
        declared_next  = declared_reg;
        staged_next    = staged_reg;
        active_next    = active_reg;
        committed_next = committed_reg;
        push           = 1'b0;
        push_cmd       = '0;
        wrote          = 1'b0;
        restart        = 1'b0;
        status         = ST_ACCEPTED;
        d              = pos_reg - POS_W'(HEADER_BYTES);
        len16          = {len_hi_reg, item.data_byte};

        if (take)
        begin
            if (item.opcode == OP_READ)
            begin
                push          = 1'b1;
                push_cmd.emit = 1'b1;
                push_cmd.kind = KIND_READ;
                push_cmd.do_read = enable_reg
                    && (32'(item.channel_index) < 32'(committed_reg))
                    && (32'(item.channel_index) < CHANNELS);
                push_cmd.addr = ADDR_W'(32'(item.channel_index)
                                        + (active_reg ? CHANNELS : 0));
            end
            else if (!enable_reg)
            begin
                restart = item.last_byte;
            end
            else
            begin
                if (32'(pos_reg) < MAX_DATAGRAM)
                begin
                    pos_next = pos_reg + POS_W'(1);
                    if (32'(pos_reg) < ID_BYTES)
                    begin
                        if (item.data_byte != id_char(pos_reg[2:0]))
                            id_ok_next = 1'b0;
                    end
                    else if (32'(pos_reg) == 8)
                        opc_next[7:0] = item.data_byte;
                    else if (32'(pos_reg) == 9)
                        opc_next[15:8] = item.data_byte;
                    else if (32'(pos_reg) == 14)
                        univ_next[7:0] = item.data_byte;
                    else if (32'(pos_reg) == 15)
                        univ_next[15:8] = item.data_byte;
                    else if (32'(pos_reg) == 16)
                        len_hi_next = item.data_byte;
                    else if (32'(pos_reg) == 17)
                    begin
                        if (32'(len16) > CHANNELS)
                            declared_next = LEN_W'(CHANNELS);
                        else
                            declared_next = LEN_W'(len16);
                    end
                    else if (32'(pos_reg) >= HEADER_BYTES)
                    begin
                        if ((32'(d) < 32'(declared_reg)) && (32'(d) < CHANNELS))
                        begin
                            // data lands in the bank that is not visible
                            wrote         = 1'b1;
                            staged_next   = LEN_W'(32'(d) + 1);
                            push_cmd.addr = ADDR_W'(32'(d) + (active_reg ? 0 : CHANNELS));
                            push_cmd.data = item.data_byte;
                        end
                    end
                end

                if (item.last_byte)
                begin
                    if (32'(pos_next) < HEADER_BYTES)
                        status = ST_TOO_SHORT;
                    else if (!id_ok_next)
                        status = ST_BAD_ID;
                    else if (opc_next != ARTDMX_OPCODE)
                        status = ST_BAD_OPCODE;
                    else if (univ_next != (wanted_reg - 16'd1))
                        status = ST_OTHER_UNIVERSE;
                    else
                        status = ST_ACCEPTED;

                    if (status == ST_ACCEPTED)
                    begin
                        active_next    = ~active_reg;
                        committed_next = (staged_next < declared_next) ? staged_next
                                                                       : declared_next;
                    end
                    restart = 1'b1;
                end

                push              = wrote || item.last_byte;
                push_cmd.do_write = wrote;
                push_cmd.emit     = item.last_byte;
                push_cmd.kind     = KIND_VERDICT;
                push_cmd.status   = status;
            end
        end

        if (wr_en)
        begin
            case (wr_index)
                REG_RECEIVE_ENABLE:
                begin
                    enable_next = wr_data[0];
                    restart     = 1'b1;
                end
                REG_WANTED_UNIVERSE: wanted_next = wr_data;
                default: ;
            endcase
        end

        if (restart)
        begin
            pos_next      = '0;
            id_ok_next    = 1'b1;
            opc_next      = '0;
            univ_next     = '0;
            len_hi_next   = '0;
            declared_next = '0;
            staged_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b0;
            wanted_reg    <= 16'd1;
            pos_reg       <= '0;
            id_ok_reg     <= 1'b1;
            opc_reg       <= '0;
            univ_reg      <= '0;
            len_hi_reg    <= '0;
            declared_reg  <= '0;
            staged_reg    <= '0;
            active_reg    <= 1'b0;
            committed_reg <= '0;
        end
        else
        begin
            enable_reg    <= enable_next;
            wanted_reg    <= wanted_next;
            pos_reg       <= pos_next;
            id_ok_reg     <= id_ok_next;
            opc_reg       <= opc_next;
            univ_reg      <= univ_next;
            len_hi_reg    <= len_hi_next;
            declared_reg  <= declared_next;
            staged_reg    <= staged_next;
            active_reg    <= active_next;
            committed_reg <= committed_next;
        end
    end

endmodule

// ===== design/artdmx_cmdq.sv =====
`timescale 1ns / 1ps

module artdmx_cmdq
    import artdmx_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head_cmd
);

    cmd_t                   entries_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   do_push;
    logic                   do_pop;

    assign full       = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entries_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QUEUE_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QUEUE_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + QUEUE_CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - QUEUE_CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== design/artdmx_back.sv =====
`timescale 1ns / 1ps

module artdmx_back
    import artdmx_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEFAULT
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    head_valid,
    input  cmd_t    head_cmd,
    output logic    pop,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    localparam int MEM_AW = $clog2(2 * CHANNELS);

    logic [7:0]  frame_mem [2 * CHANNELS];
    logic [7:0]  rd_data_reg;

    logic        s1_valid_reg, s1_valid_next;
    logic        s1_kind_reg;
    logic        s1_use_mem_reg;
    logic [2:0]  s1_status_reg;

    logic        out_valid_reg, out_valid_next;
    result_t     out_reg;

    logic        out_free;
    logic        take;

    assign out_free     = !out_valid_reg || !result_stall;
    assign pop          = !s1_valid_reg || out_free;
    assign take         = pop && head_valid;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // one memory access per transfer: a staging write or a frame read
    always_ff @(posedge clk)
    begin
        if (take && head_cmd.do_write)
            frame_mem[head_cmd.addr[MEM_AW-1:0]] <= head_cmd.data;
        if (take && head_cmd.do_read)
            rd_data_reg <= frame_mem[head_cmd.addr[MEM_AW-1:0]];
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (pop)
            s1_valid_next = take && head_cmd.emit;
        out_valid_next = out_valid_reg;
        if (out_free)
            out_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_kind_reg    <= head_cmd.kind;
            s1_use_mem_reg <= head_cmd.do_read;
            s1_status_reg  <= head_cmd.status;
        end
        if (out_free && s1_valid_reg)
        begin
            out_reg.result_kind   <= s1_kind_reg;
            out_reg.channel_value <= s1_use_mem_reg ? rd_data_reg : 8'd0;
            out_reg.packet_status <= s1_status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== design/artdmx_universe_receiver.sv =====
`timescale 1ns / 1ps

// channel  valid         stall         payload
// items    item_valid    item_stall    item   (push a datagram byte / read a channel)
// results  result_valid  result_stall  result (packet verdict / channel level)
//
// one item per cycle on each side while nothing stalls: the front parses each byte
// as it is taken and the back does one frame memory access per cycle; an item's result
// passes through the queue entry, the stage-1 registers and the output register before
// result_valid rises.
// reset clears parser and queue state and sets the committed length to zero, so
// there is no memory clearing pass.
// a four-entry queue sits between front and back; item_stall rises only when it is full.

module artdmx_universe_receiver
    import artdmx_pkg::*;
#(
    parameter int CHANNELS     = CHANNELS_DEFAULT,
    parameter int MAX_DATAGRAM = MAX_DATAGRAM_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [REG_INDEX_W-1:0] wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  item_t                  item,
    output logic                   result_valid,
    input  logic                   result_stall,
    output result_t                result
);

    logic push;
    cmd_t push_cmd;
    logic full;
    logic pop;
    logic head_valid;
    cmd_t head_cmd;

    assign item_stall = full;

    artdmx_front #(
        .CHANNELS     (CHANNELS),
        .MAX_DATAGRAM (MAX_DATAGRAM)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .take     (item_valid && !full),
        .item     (item),
        .push     (push),
        .push_cmd (push_cmd)
    );

    artdmx_cmdq u_cmdq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    artdmx_back #(
        .CHANNELS (CHANNELS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_cmd     (head_cmd),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ===== design/artdmx_checker.sv =====
`timescale 1ns / 1ps

module artdmx_checker
    import artdmx_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    input  logic    item_stall,
    input  logic    result_valid,
    input  logic    result_stall,
    input  result_t result
);

    // a held result must not move while the sink stalls
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    a_verdict_value: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.result_kind == KIND_VERDICT |-> result.channel_value == 8'd0)
        else $error("verdict carries a channel value");

    a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.result_kind == KIND_VERDICT |->
            result.packet_status == ST_ACCEPTED || result.packet_status == ST_TOO_SHORT
            || result.packet_status == ST_BAD_ID || result.packet_status == ST_BAD_OPCODE
            || result.packet_status == ST_OTHER_UNIVERSE)
        else $error("verdict status out of range");

    a_read_status: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.result_kind == KIND_READ |-> result.packet_status == ST_ACCEPTED)
        else $error("read result carries a status");

    // queue fills only through item transfers, so stall cannot appear from idle
    a_stall_needs_work: assert property (@(posedge clk) disable iff (!rst_n)
        !item_stall && !item_valid |=> !item_stall)
        else $error("input stalled with no new transfer");

endmodule

bind artdmx_universe_receiver artdmx_checker u_artdmx_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
